// ----- rtl/segment_reorder_buffer_assert.svh -----
// Assertion macros used by the segment reorder buffer checker.
`ifndef SEGMENT_REORDER_BUFFER_ASSERT_SVH
`define SEGMENT_REORDER_BUFFER_ASSERT_SVH

// Same-cycle implication, disabled while reset is asserted.
`define SRB_ASSERT_IMPLY(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// Next-cycle implication, disabled while reset is asserted.
`define SRB_ASSERT_NEXT(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

// ----- rtl/srb_pkg.sv -----
// Package with the types, widths and constants of the segment reorder buffer.
`timescale 1ns / 1ps
`default_nettype none

package srb_pkg;

    localparam int SRB_HOLD_DEPTH    = 8;
    localparam int SRB_MAX_SEG_BYTES = 1024;

    localparam int SRB_OFF_W     = 32;
    localparam int SRB_LEN_W     = 11;
    localparam int SRB_TAG_W     = 8;
    localparam int SRB_S_TDATA_W = 56;
    localparam int SRB_M_TDATA_W = 56;
    localparam int SRB_M_TUSER_W = 4;

    localparam logic [SRB_LEN_W-1:0] SRB_MAX_LEN = SRB_LEN_W'(SRB_MAX_SEG_BYTES);

    localparam logic SRB_KIND_DELIVER = 1'b0;
    localparam logic SRB_KIND_ACK     = 1'b1;

    typedef struct packed {
        logic [SRB_TAG_W-1:0] tag;
        logic                 chan;
        logic                 last;
        logic [SRB_LEN_W-1:0] len;
        logic [SRB_OFF_W-1:0] off;
    } srb_seg_t;

    typedef struct packed {
        logic                 kind;
        logic [SRB_OFF_W-1:0] offset;
        logic [SRB_LEN_W-1:0] length;
        logic                 last;
        logic                 channel;
        logic [SRB_TAG_W-1:0] tag;
        logic                 run_end;
        logic                 stream_done;
        logic                 overflow;
    } srb_result_t;

    typedef struct packed {
        logic        load;
        srb_result_t result;
    } srb_out_req_t;

endpackage

`default_nettype wire

// ----- rtl/srb_hold_mem.sv -----
// Synchronous memory holding the out-of-order segments, with registered read data.
`timescale 1ns / 1ps
`default_nettype none

module srb_hold_mem #(
    parameter int DEPTH = srb_pkg::SRB_HOLD_DEPTH,
    parameter int AW    = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
    input  wire                logic clk,
    input  wire                logic we,
    input  wire                logic [AW-1:0] waddr,
    input  wire srb_pkg::srb_seg_t wdata,
    input  wire                logic [AW-1:0] raddr,
    output srb_pkg::srb_seg_t  rdata
);
    import srb_pkg::*;

    srb_seg_t mem [DEPTH];

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        rdata <= mem[raddr];
    end

endmodule

`default_nettype wire

// ----- rtl/srb_out_stage.sv -----
// Output register that presents one result request on the master stream.
`timescale 1ns / 1ps
`default_nettype none

module srb_out_stage (
    input  wire logic                 clk,
    input  wire logic                 rst_n,
    input  wire srb_pkg::srb_out_req_t req,
    output logic                      free,
    output logic                      m_tvalid,
    input  wire logic                 m_tready,
    // Fields from bit 0 up: out_offset, out_length, out_last, out_tag, zero fill.
    output logic [srb_pkg::SRB_M_TDATA_W-1:0] m_tdata,
    output logic                      m_tlast,
    // Fields from bit 0 up: kind, out_channel, stream_done, overflow.
    output logic [srb_pkg::SRB_M_TUSER_W-1:0] m_tuser
);
    import srb_pkg::*;

    logic        valid_reg;
    srb_result_t res_reg;

    assign free = !valid_reg || m_tready;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= 1'b0;
        end
        else if (free)
        begin
            valid_reg <= req.load;
        end
    end

    always_ff @(posedge clk)
    begin
        if (free && req.load)
        begin
            res_reg <= req.result;
        end
    end

    assign m_tvalid = valid_reg;
    assign m_tdata  = {4'd0, res_reg.tag, res_reg.last, res_reg.length, res_reg.offset};
    assign m_tlast  = res_reg.run_end;
    assign m_tuser  = {res_reg.overflow, res_reg.stream_done, res_reg.channel, res_reg.kind};

endmodule

`default_nettype wire

// ----- rtl/srb_ctrl.sv -----
// Sequencer that walks, inserts into and drains the held-segment ring.
`timescale 1ns / 1ps
`default_nettype none

module srb_ctrl #(
    parameter int DEPTH = srb_pkg::SRB_HOLD_DEPTH,
    parameter int AW    = (DEPTH > 1) ? $clog2(DEPTH) : 1,
    parameter int CW    = $clog2(DEPTH + 1)
) (
    input  wire logic                 clk,
    input  wire logic                 rst_n,
    input  wire logic                 cfg_we,
    input  wire logic [31:0]          cfg_wdata,
    input  wire logic                 s_tvalid,
    output logic                      s_tready,
    input  wire logic [srb_pkg::SRB_S_TDATA_W-1:0] s_tdata,
    input  wire logic                 s_tlast,
    input  wire logic                 s_tuser,
    output logic                      mem_we,
    output logic [AW-1:0]             mem_waddr,
    output srb_pkg::srb_seg_t         mem_wdata,
    output logic [AW-1:0]             mem_raddr,
    input  wire srb_pkg::srb_seg_t    mem_rdata,
    input  wire logic                 out_free,
    output srb_pkg::srb_out_req_t     out_req
);
    import srb_pkg::*;

    typedef enum logic [3:0] {
        ST_IDLE,
        ST_D_RD,
        ST_D_EV,
        ST_FIRST,
        ST_COMMIT,
        ST_ACK,
        ST_OVF,
        ST_S_RD,
        ST_S_EV,
        ST_S_DEC,
        ST_SH_RD,
        ST_SH_WR,
        ST_INS
    } state_t;

    state_t               state_reg, state_next;
    srb_seg_t             seg_reg, seg_next;
    logic [SRB_OFF_W-1:0] exp_reg, exp_next;
    logic [SRB_OFF_W-1:0] walk_reg, walk_next;
    logic [SRB_OFF_W-1:0] base_reg, base_next;
    logic [AW-1:0]        head_reg, head_next;
    logic [CW-1:0]        count_reg, count_next;
    logic [CW-1:0]        j_reg, j_next;
    logic [CW-1:0]        pos_reg, pos_next;
    logic                 dup_reg, dup_next;
    logic                 done_reg, done_next;
    logic                 pre_done_reg, pre_done_next;
    logic                 phase_reg, phase_next;

    srb_seg_t             in_seg;
    logic [16:0]          in_len_wide;
    logic [SRB_OFF_W-1:0] in_end;

    function automatic logic [AW-1:0] ring_addr(input logic [AW-1:0] base,
                                                input logic [CW-1:0] rel);
        logic [CW:0] sum;
        sum = (CW+1)'(base) + (CW+1)'(rel);
        if (sum >= (CW+1)'(DEPTH))
        begin
            sum = sum - (CW+1)'(DEPTH);
        end
        return sum[AW-1:0];
    endfunction

    function automatic srb_result_t make_result(input logic kind, input srb_seg_t s,
                                                input logic run_end, input logic done,
                                                input logic ovf);
        srb_result_t r;
        r.kind        = kind;
        r.offset      = s.off;
        r.length      = (kind == SRB_KIND_ACK) ? '0 : s.len;
        r.last        = (kind == SRB_KIND_ACK) ? 1'b0 : s.last;
        r.channel     = s.chan;
        r.tag         = (kind == SRB_KIND_ACK) ? '0 : s.tag;
        r.run_end     = run_end;
        r.stream_done = done;
        r.overflow    = ovf;
        return r;
    endfunction

    always_comb
    begin
        in_len_wide = {6'd0, s_tdata[42:32]};
        in_seg.off  = s_tdata[31:0];
        in_seg.len  = (in_len_wide > 17'(SRB_MAX_SEG_BYTES)) ? SRB_MAX_LEN : s_tdata[42:32];
        in_seg.last = s_tlast;
        in_seg.chan = s_tuser;
        in_seg.tag  = s_tdata[50:43];
        in_end      = exp_reg + {21'd0, in_seg.len};
    end

    assign mem_raddr = ring_addr(head_reg, j_reg);

    always_comb
    begin
        state_next    = state_reg;
        seg_next      = seg_reg;
        exp_next      = exp_reg;
        walk_next     = walk_reg;
        base_next     = base_reg;
        head_next     = head_reg;
        count_next    = count_reg;
        j_next        = j_reg;
        pos_next      = pos_reg;
        dup_next      = dup_reg;
        done_next     = done_reg;
        pre_done_next = pre_done_reg;
        phase_next    = phase_reg;
        s_tready      = (state_reg == ST_IDLE);
        mem_we        = 1'b0;
        mem_waddr     = ring_addr(head_reg, j_reg + CW'(1));
        mem_wdata     = mem_rdata;
        out_req       = '0;

        case (state_reg)
            ST_IDLE:
            begin
                if (s_tvalid && !done_reg)
                begin
                    seg_next = in_seg;
                    j_next   = '0;
                    if (in_seg.off == exp_reg)
                    begin
                        base_next     = in_end;
                        walk_next     = in_end;
                        pre_done_next = in_seg.last;
                        phase_next    = 1'b0;
                        state_next    = in_seg.last ? ST_FIRST : ST_D_RD;
                    end
                    else if (in_seg.off < exp_reg)
                    begin
                        state_next = ST_ACK;
                    end
                    else
                    begin
                        dup_next   = 1'b0;
                        pos_next   = '0;
                        state_next = ST_S_RD;
                    end
                end
                if (cfg_we)
                begin
                    exp_next = cfg_wdata;
                end
            end
            ST_D_RD:
            begin
                if (j_reg == count_reg)
                begin
                    state_next = phase_reg ? ST_COMMIT : ST_FIRST;
                end
                else
                begin
                    state_next = ST_D_EV;
                end
            end
            ST_D_EV:
            begin
                if (mem_rdata.off == walk_reg)
                begin
                    if (!phase_reg || out_free)
                    begin
                        if (phase_reg)
                        begin
                            out_req.load   = 1'b1;
                            out_req.result = make_result(SRB_KIND_DELIVER, mem_rdata, 1'b0,
                                                         pre_done_reg, 1'b0);
                        end
                        walk_next = walk_reg + {21'd0, mem_rdata.len};
                        j_next    = j_reg + CW'(1);
                        if (mem_rdata.last)
                        begin
                            pre_done_next = 1'b1;
                            state_next    = phase_reg ? ST_COMMIT : ST_FIRST;
                        end
                        else
                        begin
                            state_next = ST_D_RD;
                        end
                    end
                end
                else if (mem_rdata.off < walk_reg)
                begin
                    j_next     = j_reg + CW'(1);
                    state_next = ST_D_RD;
                end
                else
                begin
                    state_next = phase_reg ? ST_COMMIT : ST_FIRST;
                end
            end
            ST_FIRST:
            begin
                if (out_free)
                begin
                    out_req.load   = 1'b1;
                    out_req.result = make_result(SRB_KIND_DELIVER, seg_reg, 1'b0,
                                                 pre_done_reg, 1'b0);
                    j_next         = '0;
                    walk_next      = base_reg;
                    phase_next     = 1'b1;
                    state_next     = seg_reg.last ? ST_COMMIT : ST_D_RD;
                end
            end
            ST_COMMIT:
            begin
                exp_next   = walk_reg;
                done_next  = pre_done_reg;
                head_next  = ring_addr(head_reg, j_reg);
                count_next = count_reg - j_reg;
                state_next = ST_ACK;
            end
            ST_ACK:
            begin
                if (out_free)
                begin
                    out_req.load   = 1'b1;
                    out_req.result = make_result(SRB_KIND_ACK, seg_reg, 1'b1, done_reg, 1'b0);
                    state_next     = ST_IDLE;
                end
            end
            ST_OVF:
            begin
                if (out_free)
                begin
                    out_req.load   = 1'b1;
                    out_req.result = make_result(SRB_KIND_ACK, seg_reg, 1'b1, done_reg, 1'b1);
                    state_next     = ST_IDLE;
                end
            end
            ST_S_RD:
            begin
                state_next = (j_reg == count_reg) ? ST_S_DEC : ST_S_EV;
            end
            ST_S_EV:
            begin
                if (mem_rdata.off == seg_reg.off)
                begin
                    dup_next = 1'b1;
                end
                if (mem_rdata.off < seg_reg.off)
                begin
                    pos_next = j_reg + CW'(1);
                end
                j_next     = j_reg + CW'(1);
                state_next = ST_S_RD;
            end
            ST_S_DEC:
            begin
                if (dup_reg)
                begin
                    state_next = ST_ACK;
                end
                else if (count_reg == CW'(DEPTH))
                begin
                    state_next = ST_OVF;
                end
                else if (count_reg == pos_reg)
                begin
                    state_next = ST_INS;
                end
                else
                begin
                    j_next     = count_reg - CW'(1);
                    state_next = ST_SH_RD;
                end
            end
            ST_SH_RD:
            begin
                state_next = ST_SH_WR;
            end
            ST_SH_WR:
            begin
                mem_we = 1'b1;
                if (j_reg == pos_reg)
                begin
                    state_next = ST_INS;
                end
                else
                begin
                    j_next     = j_reg - CW'(1);
                    state_next = ST_SH_RD;
                end
            end
            ST_INS:
            begin
                mem_we     = 1'b1;
                mem_waddr  = ring_addr(head_reg, pos_reg);
                mem_wdata  = seg_reg;
                count_next = count_reg + CW'(1);
                state_next = ST_ACK;
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg    <= ST_IDLE;
            exp_reg      <= '0;
            head_reg     <= '0;
            count_reg    <= '0;
            j_reg        <= '0;
            pos_reg      <= '0;
            dup_reg      <= 1'b0;
            done_reg     <= 1'b0;
            pre_done_reg <= 1'b0;
            phase_reg    <= 1'b0;
        end
        else
        begin
            state_reg    <= state_next;
            exp_reg      <= exp_next;
            head_reg     <= head_next;
            count_reg    <= count_next;
            j_reg        <= j_next;
            pos_reg      <= pos_next;
            dup_reg      <= dup_next;
            done_reg     <= done_next;
            pre_done_reg <= pre_done_next;
            phase_reg    <= phase_next;
        end
    end

    always_ff @(posedge clk)
    begin
        seg_reg  <= seg_next;
        walk_reg <= walk_next;
        base_reg <= base_next;
    end

endmodule

`default_nettype wire

// ----- rtl/segment_reorder_buffer.sv -----
// Top level of the segment reorder buffer.
`timescale 1ns / 1ps
`default_nettype none

// The block reassembles a byte stream from segment descriptors that may arrive out
// of order, holding up to HOLD_DEPTH early segments in a ring memory sorted by offset.
// One request is taken at a time. A request that arrives after the stream end was
// delivered is taken and dropped with no result; a stale segment is acknowledged. A
// duplicate is acknowledged after a search of the held entries, and a segment that
// finds the buffer full is dropped with an overflow notice. An out-of-order segment
// is inserted after the held entries above its position are shifted up. An in-order
// segment walks the held entries that follow it; the walk stops at the end of the
// held entries, at a gap or at an end-flagged entry, and an end-flagged in-order
// segment skips the walk. The sequencer waits while the output register cannot take
// a result. The hold memory has a single read port with registered read data, and
// each in-order request walks the held entries twice so that every result already
// shows the final stream_done value. Results leave through an output register, so
// the last result of a request may wait there while the next request is taken.
// Writing cfg_wdata with cfg_we while the block is idle sets the start offset and
// reloads the expected offset.

module segment_reorder_buffer #(
    parameter int HOLD_DEPTH = srb_pkg::SRB_HOLD_DEPTH
) (
    input  wire logic        clk,
    input  wire logic        rst_n,
    input  wire logic        cfg_we,
    input  wire logic [31:0] cfg_wdata,
    input  wire logic        s_tvalid,
    output logic             s_tready,
    // Fields from bit 0 up: seg_offset, seg_length, payload_tag, zero fill.
    input  wire logic [srb_pkg::SRB_S_TDATA_W-1:0] s_tdata,
    input  wire logic        s_tlast,
    // Fields from bit 0 up: seg_channel.
    input  wire logic [0:0]  s_tuser,
    output logic             m_tvalid,
    input  wire logic        m_tready,
    // Fields from bit 0 up: out_offset, out_length, out_last, out_tag, zero fill.
    output logic [srb_pkg::SRB_M_TDATA_W-1:0] m_tdata,
    output logic             m_tlast,
    // Fields from bit 0 up: kind, out_channel, stream_done, overflow.
    output logic [srb_pkg::SRB_M_TUSER_W-1:0] m_tuser
);
    import srb_pkg::*;

    localparam int AW = (HOLD_DEPTH > 1) ? $clog2(HOLD_DEPTH) : 1;
    localparam int CW = $clog2(HOLD_DEPTH + 1);

    logic         mem_we;
    logic [AW-1:0] mem_waddr;
    logic [AW-1:0] mem_raddr;
    srb_seg_t     mem_wdata;
    srb_seg_t     mem_rdata;
    logic         out_free;
    srb_out_req_t out_req;

    srb_hold_mem #(
        .DEPTH (HOLD_DEPTH),
        .AW    (AW)
    ) u_mem (
        .clk   (clk),
        .we    (mem_we),
        .waddr (mem_waddr),
        .wdata (mem_wdata),
        .raddr (mem_raddr),
        .rdata (mem_rdata)
    );

    srb_ctrl #(
        .DEPTH (HOLD_DEPTH),
        .AW    (AW),
        .CW    (CW)
    ) u_ctrl (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg_we    (cfg_we),
        .cfg_wdata (cfg_wdata),
        .s_tvalid  (s_tvalid),
        .s_tready  (s_tready),
        .s_tdata   (s_tdata),
        .s_tlast   (s_tlast),
        .s_tuser   (s_tuser[0]),
        .mem_we    (mem_we),
        .mem_waddr (mem_waddr),
        .mem_wdata (mem_wdata),
        .mem_raddr (mem_raddr),
        .mem_rdata (mem_rdata),
        .out_free  (out_free),
        .out_req   (out_req)
    );

    srb_out_stage u_out (
        .clk      (clk),
        .rst_n    (rst_n),
        .req      (out_req),
        .free     (out_free),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata),
        .m_tlast  (m_tlast),
        .m_tuser  (m_tuser)
    );

endmodule

`default_nettype wire

// ----- rtl/srb_checker.sv -----
// Port-level checker for the segment reorder buffer and its bind statement.
`timescale 1ns / 1ps
`default_nettype none

`include "segment_reorder_buffer_assert.svh"

module srb_checker (
    input wire logic clk,
    input wire logic rst_n,
    input wire logic m_tvalid,
    input wire logic m_tready,
    input wire logic [srb_pkg::SRB_M_TDATA_W-1:0] m_tdata,
    input wire logic m_tlast,
    input wire logic [srb_pkg::SRB_M_TUSER_W-1:0] m_tuser
);
    import srb_pkg::*;

    logic [SRB_M_TDATA_W+SRB_M_TUSER_W+1:0] out_word;
    logic out_stall;
    logic out_ack;
    logic out_drop;
    logic out_deliver;
    logic no_payload;
    logic final_ack;
    logic not_final;

    assign out_word    = {m_tvalid, m_tlast, m_tuser, m_tdata};
    assign out_stall   = m_tvalid && !m_tready;
    assign out_ack     = m_tvalid && m_tuser[0];
    assign out_drop    = m_tvalid && m_tuser[3];
    assign out_deliver = m_tvalid && !m_tuser[0];
    assign no_payload  = (m_tdata[51:32] == 20'd0);
    assign final_ack   = m_tuser[0] && m_tlast;
    assign not_final   = !m_tlast && !m_tuser[3];

    // A stalled result keeps its contents until it is taken.
    `SRB_ASSERT_NEXT(a_out_hold, clk, rst_n, out_stall, $stable(out_word), "held result changed")

    // An acknowledgment or drop notice carries no length, end flag or tag.
    `SRB_ASSERT_IMPLY(a_ack_clean, clk, rst_n, out_ack, no_payload, "acknowledgment has payload")

    // A drop notice is an acknowledgment kind and ends its request.
    `SRB_ASSERT_IMPLY(a_ovf_final, clk, rst_n, out_drop, final_ack, "drop notice not final ack")

    // A delivery never ends its request and is never a drop notice.
    `SRB_ASSERT_IMPLY(a_deliver_mid, clk, rst_n, out_deliver, not_final, "delivery ends request")

endmodule

bind segment_reorder_buffer srb_checker u_srb_checker (
    .clk      (clk),
    .rst_n    (rst_n),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata),
    .m_tlast  (m_tlast),
    .m_tuser  (m_tuser)
);

`default_nettype wire
